// File: rtl/aldb_pkg.sv
// shared types, constants and helpers for the analog ladder button debounce
package aldb_pkg;

  localparam int MaxButtonsDef = 6;
  localparam int SampleBitsDef = 10;
  localparam int LevelBits     = 10;
  localparam int MaskBits      = 6;
  localparam int IndexBits     = 3;
  localparam int TolBits       = 10;
  localparam int DebBits       = 16;
  localparam int CountBits     = 3;
  localparam int LevelsBits    = MaskBits * LevelBits;
  localparam int StoreBits     = 14;
  localparam int TimeBits      = 32;
  localparam int CfgIdxBits    = 3;
  localparam int CfgDataBits   = LevelsBits;

  localparam logic [StoreBits-1:0] NoLevel       = 14'd10000;
  localparam logic [DebBits-1:0]   DebounceReset = 16'd50;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegEnabled     = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegTolerance   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegDebounceMs  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegButtonCount = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegLevels      = 3'd4;

  typedef struct packed {
    logic                  enabled;
    logic [TolBits-1:0]    tolerance;
    logic [DebBits-1:0]    debounce_ms;
    logic [CountBits-1:0]  button_count;
    logic [LevelsBits-1:0] levels;
  } cfg_t;

  // inclusive window centre +/- half, no negative wrap
  function automatic logic win_hit(input logic [StoreBits-1:0] value,
                                   input logic [StoreBits-1:0] centre,
                                   input logic [TolBits-1:0]   half);
    logic [StoreBits:0] lo_sum;
    logic [StoreBits:0] hi_sum;
    lo_sum = {1'b0, value} + (StoreBits+1)'(half);
    hi_sum = {1'b0, centre} + (StoreBits+1)'(half);
    return (lo_sum >= {1'b0, centre}) && ({1'b0, value} <= hi_sum);
  endfunction

endpackage

// File: rtl/aldb_if.sv
// valid/ready channel interfaces for samples and results
interface aldb_in_if #(
  parameter int SAMPLE_BITS = aldb_pkg::SampleBitsDef
);
  logic                                valid;
  logic                                ready;
  logic [SAMPLE_BITS-1:0]              reading;
  logic [aldb_pkg::TimeBits-1:0]       now_ms;

  modport source (output valid, output reading, output now_ms, input ready);
  modport sink   (input valid, input reading, input now_ms, output ready);
endinterface

interface aldb_out_if;
  logic                                valid;
  logic                                ready;
  logic                                pressed;
  logic [aldb_pkg::IndexBits-1:0]      button_index;
  logic [aldb_pkg::MaskBits-1:0]       match_mask;

  modport source (output valid, output pressed, output button_index, output match_mask,
                  input ready);
  modport sink   (input valid, input pressed, input button_index, input match_mask,
                  output ready);
endinterface

// File: rtl/analog_ladder_button_debounce.sv
// top level: sample register, debounce state and result register
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    reading, now_ms
//   out_chan  out  valid/ready    pressed, button_index, match_mask
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// one item per cycle sustained while out_chan is ready; each item passes the sample register, then the result register
// the debounce state is updated as an item moves from the sample register to the result
// register, so each item sees the state left by the one before it
// reset clears the debounce state to no known level, disarmed, and the registers to defaults
// a stall on out_chan holds both stages; in_chan ready falls only when both are full
module analog_ladder_button_debounce #(
  parameter int MAX_BUTTONS = aldb_pkg::MaxButtonsDef,
  parameter int SAMPLE_BITS = aldb_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  aldb_in_if.sink                           in_chan,
  aldb_out_if.source                        out_chan,
  input  logic                              cfg_we_i,
  input  logic [aldb_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [aldb_pkg::CfgDataBits-1:0]  cfg_wdata_i
);

  aldb_pkg::cfg_t cfg;

  // sample register
  logic                           smp_valid_q;
  logic [SAMPLE_BITS-1:0]         smp_reading_q;
  logic [aldb_pkg::TimeBits-1:0]  smp_now_q;

  // debounce state
  logic [aldb_pkg::StoreBits-1:0] stored_q, stored_d;
  logic                           armed_q, armed_d;
  logic [aldb_pkg::TimeBits-1:0]  change_time_q, change_time_d;

  // result register
  logic                           res_valid_q;
  logic                           res_pressed_q, res_pressed_d;
  logic [aldb_pkg::IndexBits-1:0] res_index_q, res_index_d;
  logic [aldb_pkg::MaskBits-1:0]  res_mask_q, res_mask_d;

  logic                           res_adv;
  logic                           smp_move;
  logic                           in_take;
  logic [aldb_pkg::StoreBits-1:0] value;
  logic [aldb_pkg::TimeBits-1:0]  elapsed;
  logic                           in_win;
  logic                           settled;
  logic [aldb_pkg::MaskBits-1:0]  lane_mask;
  logic [aldb_pkg::IndexBits-1:0] lane_index;

  aldb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign value   = aldb_pkg::StoreBits'(smp_reading_q);
  assign elapsed = smp_now_q - change_time_q;
  assign in_win  = aldb_pkg::win_hit(value, stored_q, cfg.tolerance);
  assign settled = elapsed > aldb_pkg::TimeBits'(cfg.debounce_ms);

  aldb_match #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_match (
    .value_i        (value),
    .tolerance_i    (cfg.tolerance),
    .button_count_i (cfg.button_count),
    .levels_i       (cfg.levels),
    .mask_o         (lane_mask),
    .index_o        (lane_index)
  );

  assign res_adv  = !res_valid_q || out_chan.ready;
  assign smp_move = smp_valid_q && res_adv;
  assign in_take  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !smp_valid_q || res_adv;

  always_comb begin
    stored_d      = stored_q;
    armed_d       = armed_q;
    change_time_d = change_time_q;
    res_pressed_d = 1'b0;
    res_index_d   = '0;
    res_mask_d    = '0;
    if (cfg.enabled) begin
      if (!armed_q) begin
        if (!in_win) begin
          armed_d       = 1'b1;
          change_time_d = smp_now_q;
          stored_d      = value;
        end
      end else if (settled) begin
        // a judged sample that left the window reports nothing
        if (in_win) begin
          res_pressed_d = |lane_mask;
          res_index_d   = lane_index;
          res_mask_d    = lane_mask;
        end
        armed_d  = 1'b0;
        stored_d = value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q   <= 1'b0;
      res_valid_q   <= 1'b0;
      stored_q      <= aldb_pkg::NoLevel;
      armed_q       <= 1'b0;
      change_time_q <= '0;
    end else begin
      if (in_take) begin
        smp_valid_q <= 1'b1;
      end else if (smp_move) begin
        smp_valid_q <= 1'b0;
      end
      if (res_adv) begin
        res_valid_q <= smp_valid_q;
      end
      if (smp_move) begin
        stored_q      <= stored_d;
        armed_q       <= armed_d;
        change_time_q <= change_time_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      smp_reading_q <= in_chan.reading;
      smp_now_q     <= in_chan.now_ms;
    end
    if (smp_move) begin
      res_pressed_q <= res_pressed_d;
      res_index_q   <= res_index_d;
      res_mask_q    <= res_mask_d;
    end
  end

  assign out_chan.valid        = res_valid_q;
  assign out_chan.pressed      = res_pressed_q;
  assign out_chan.button_index = res_index_q;
  assign out_chan.match_mask   = res_mask_q;

endmodule

// File: rtl/aldb_cfg.sv
// configuration register file
module aldb_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aldb_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [aldb_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  output aldb_pkg::cfg_t                     cfg_o
);

  aldb_pkg::cfg_t cfg_q;
  aldb_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aldb_pkg::RegEnabled:     cfg_d.enabled      = cfg_wdata_i[0];
        aldb_pkg::RegTolerance:   cfg_d.tolerance    = cfg_wdata_i[aldb_pkg::TolBits-1:0];
        aldb_pkg::RegDebounceMs:  cfg_d.debounce_ms  = cfg_wdata_i[aldb_pkg::DebBits-1:0];
        aldb_pkg::RegButtonCount: cfg_d.button_count = cfg_wdata_i[aldb_pkg::CountBits-1:0];
        aldb_pkg::RegLevels:      cfg_d.levels       = cfg_wdata_i[aldb_pkg::LevelsBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled      <= 1'b0;
      cfg_q.tolerance    <= '0;
      cfg_q.debounce_ms  <= aldb_pkg::DebounceReset;
      cfg_q.button_count <= '0;
      cfg_q.levels       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/aldb_match.sv
// parallel level match over the button lanes
module aldb_match #(
  parameter int MAX_BUTTONS = aldb_pkg::MaxButtonsDef
) (
  input  logic [aldb_pkg::StoreBits-1:0]   value_i,
  input  logic [aldb_pkg::TolBits-1:0]     tolerance_i,
  input  logic [aldb_pkg::CountBits-1:0]   button_count_i,
  input  logic [aldb_pkg::LevelsBits-1:0]  levels_i,
  output logic [aldb_pkg::MaskBits-1:0]    mask_o,
  output logic [aldb_pkg::IndexBits-1:0]   index_o
);

  localparam logic [aldb_pkg::CountBits-1:0] MaxCount =
    aldb_pkg::CountBits'(MAX_BUTTONS);

  logic [aldb_pkg::CountBits-1:0] count;
  logic [aldb_pkg::MaskBits-1:0]  mask;
  logic [aldb_pkg::IndexBits-1:0] index;

  assign count = (button_count_i > MaxCount) ? MaxCount : button_count_i;

  always_comb begin
    mask  = '0;
    index = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      if (aldb_pkg::CountBits'(i) < count &&
          aldb_pkg::win_hit(value_i,
                            aldb_pkg::StoreBits'(levels_i[i*aldb_pkg::LevelBits +:
                                                          aldb_pkg::LevelBits]),
                            tolerance_i)) begin
        mask[i] = 1'b1;
        index   = aldb_pkg::IndexBits'(i);
      end
    end
  end

  assign mask_o  = mask;
  assign index_o = index;

endmodule

// File: dv/testbench.sv
// self-checking testbench for the analog ladder button debounce block
`timescale 1ns / 100ps

module testbench;
  import aldb_pkg::*;

  localparam int ReadingMax = (1 << SampleBitsDef) - 1;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [SampleBitsDef-1:0] reading;
    logic [TimeBits-1:0]      now_ms;
  } sample_t;

  typedef struct packed {
    logic                 pressed;
    logic [IndexBits-1:0] button_index;
    logic [MaskBits-1:0]  match_mask;
  } verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  aldb_in_if #(.SAMPLE_BITS(SampleBitsDef)) in_chan ();
  aldb_out_if out_chan ();

  analog_ladder_button_debounce DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of registers and debounce state
  cfg_t                ladder_cfg;
  int                  settled_level;
  logic                timer_armed;
  logic [TimeBits-1:0] arm_stamp;

  sample_t             pending_samples[$];
  verdict_t            expected_verdicts[$];
  logic [TimeBits-1:0] stamp_ms;

  int mismatches;
  int items_taken;
  int results_checked;
  int presses_seen;
  int settings_used;
  int run_cycles;

  int       drv_gap;
  int       drv_calm;
  int       drv_roll;
  int       sink_hold;
  int       sink_calm;
  int       sink_roll;
  logic     sink_backup;
  verdict_t want;

  function automatic logic in_band(input int value, input int centre, input int half);
    return (value >= centre - half) && (value <= centre + half);
  endfunction

  function automatic verdict_t judge_sample(input logic [SampleBitsDef-1:0] reading,
                                            input logic [TimeBits-1:0]      now_ms);
    verdict_t            v;
    logic [TimeBits-1:0] elapsed;
    int                  r;
    int                  tol;
    int                  span;
    v    = '0;
    r    = int'(reading);
    tol  = int'(ladder_cfg.tolerance);
    span = (ladder_cfg.button_count > MaxButtonsDef) ? MaxButtonsDef
                                                     : int'(ladder_cfg.button_count);
    elapsed = now_ms - arm_stamp;
    if (ladder_cfg.enabled) begin
      if (!timer_armed) begin
        if (!in_band(r, settled_level, tol)) begin
          timer_armed   = 1'b1;
          arm_stamp     = now_ms;
          settled_level = r;
        end
      end else if (elapsed > {16'b0, ladder_cfg.debounce_ms}) begin
        if (in_band(r, settled_level, tol)) begin
          for (int i = 0; i < span; i++) begin
            if (in_band(r, int'(ladder_cfg.levels[LevelBits*i +: LevelBits]), tol)) begin
              v.match_mask[i] = 1'b1;
              v.button_index  = i[IndexBits-1:0];
            end
          end
        end
        timer_armed   = 1'b0;
        settled_level = r;
      end
    end
    v.pressed = |v.match_mask;
    return v;
  endfunction

  // reading near centre, at most half away, clipped to the adc range
  function automatic logic [SampleBitsDef-1:0] wobble(input int centre, input int half);
    int v;
    v = centre + int'($urandom_range(0, 2 * half)) - half;
    if (v < 0) v = 0;
    if (v > ReadingMax) v = ReadingMax;
    return v[SampleBitsDef-1:0];
  endfunction

  task automatic push_sample(input int reading, input logic [TimeBits-1:0] now_ms);
    sample_t s;
    s.reading = reading[SampleBitsDef-1:0];
    s.now_ms  = now_ms;
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegEnabled:     ladder_cfg.enabled      = data[0];
      RegTolerance:   ladder_cfg.tolerance    = data[TolBits-1:0];
      RegDebounceMs:  ladder_cfg.debounce_ms  = data[DebBits-1:0];
      RegButtonCount: ladder_cfg.button_count = data[CountBits-1:0];
      RegLevels:      ladder_cfg.levels       = data[LevelsBits-1:0];
      default: ;
    endcase
  endtask

  task automatic new_setting(input int tol, input int deb, input int count,
                             input logic [LevelsBits-1:0] lv);
    write_reg(RegTolerance, CfgDataBits'(tol));
    write_reg(RegDebounceMs, CfgDataBits'(deb));
    write_reg(RegButtonCount, CfgDataBits'(count));
    write_reg(RegLevels, CfgDataBits'(lv));
    settings_used++;
  endtask

  // hold off until every item has come back, then let the pipeline drain
  task automatic settle();
    while (pending_samples.size() != 0 || in_chan.valid || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly arm / bounce / judge sequences with random content, some plain noise
  task automatic add_press_burst(input int n_items);
    int                  made;
    int                  span;
    int                  tol;
    int                  deb;
    int                  target;
    int                  bounces;
    int                  slot;
    logic [TimeBits-1:0] arm_t;
    made = 0;
    tol  = int'(ladder_cfg.tolerance);
    deb  = int'(ladder_cfg.debounce_ms);
    span = (ladder_cfg.button_count > MaxButtonsDef) ? MaxButtonsDef
                                                     : int'(ladder_cfg.button_count);
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        push_sample($urandom_range(0, ReadingMax), $urandom());
        made++;
      end else begin
        if (span > 0 && $urandom_range(0, 9) < 7) begin
          slot   = $urandom_range(0, span - 1);
          target = wobble(int'(ladder_cfg.levels[LevelBits*slot +: LevelBits]), tol);
        end else begin
          target = $urandom_range(0, ReadingMax);
        end
        if ($urandom_range(0, 19) == 0) stamp_ms = $urandom();
        else stamp_ms = stamp_ms + $urandom_range(1, 400);
        arm_t = stamp_ms;
        push_sample(target, arm_t);
        bounces = $urandom_range(0, 3);
        repeat (bounces) begin
          if ($urandom_range(0, 3) == 0)
            push_sample($urandom_range(0, ReadingMax), arm_t + $urandom_range(0, deb));
          else
            push_sample(wobble(target, tol), arm_t + $urandom_range(0, deb));
        end
        // first moment past the settle time now and then, otherwise somewhat later
        stamp_ms = arm_t + deb + 1 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 300));
        if ($urandom_range(0, 6) == 0) push_sample($urandom_range(0, ReadingMax), stamp_ms);
        else push_sample(wobble(target, tol), stamp_ms);
        made += bounces + 2;
      end
    end
  endtask

  // sender: one item held on the channel until taken, random gaps between items
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_verdicts.push_back(judge_sample(in_chan.reading, in_chan.now_ms));
        items_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_chan.valid   <= 1'b1;
          in_chan.reading <= pending_samples[0].reading;
          in_chan.now_ms  <= pending_samples[0].now_ms;
          void'(pending_samples.pop_front());
          if (drv_calm > 0) begin
            drv_calm--;
          end else begin
            drv_roll = $urandom_range(0, 99);
            if (drv_roll < 2) drv_calm = $urandom_range(50, 200);
            else if (drv_roll < 5) drv_gap = $urandom_range(10, 40);
            else if (drv_roll < 35) drv_gap = $urandom_range(1, 3);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest expectation, stalls at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_checked++;
        if (results_checked == 400 || results_checked == 1200) sink_backup = 1'b1;
        if (expected_verdicts.size() == 0) begin
          $error("result with no item outstanding: pressed %0d index %0d mask %b",
                 out_chan.pressed, out_chan.button_index, out_chan.match_mask);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (want.pressed) presses_seen++;
          if (out_chan.pressed !== want.pressed) begin
            $error("pressed: expected %0d, got %0d", want.pressed, out_chan.pressed);
            mismatches++;
          end
          if (out_chan.button_index !== want.button_index) begin
            $error("button_index: expected %0d, got %0d", want.button_index,
                   out_chan.button_index);
            mismatches++;
          end
          if (out_chan.match_mask !== want.match_mask) begin
            $error("match_mask: expected %b, got %b", want.match_mask, out_chan.match_mask);
            mismatches++;
          end
        end
      end
      // long hold-off so the block backs up and drops its input ready
      if (sink_backup) begin
        sink_backup = 1'b0;
        sink_hold   = 200;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_chan.ready <= 1'b0;
      end else if (sink_calm > 0) begin
        sink_calm--;
        out_chan.ready <= 1'b1;
      end else begin
        sink_roll = $urandom_range(0, 999);
        if (sink_roll < 3) begin
          sink_hold = $urandom_range(20, 100);
          out_chan.ready <= 1'b0;
        end else if (sink_roll < 10) begin
          sink_calm = $urandom_range(50, 200);
          out_chan.ready <= 1'b1;
        end else if (sink_roll < 250) begin
          sink_hold = $urandom_range(0, 2);
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegEnabled;
    cfg_wdata_i     = '0;
    in_chan.valid   = 1'b0;
    in_chan.reading = '0;
    in_chan.now_ms  = '0;
    out_chan.ready  = 1'b0;
    ladder_cfg      = '0;
    ladder_cfg.debounce_ms = DebounceReset;
    settled_level   = int'(NoLevel);
    timer_armed     = 1'b0;
    arm_stamp       = '0;
    stamp_ms        = $urandom();
    mismatches      = 0;
    items_taken     = 0;
    results_checked = 0;
    presses_seen    = 0;
    settings_used   = 1;
    run_cycles      = 0;
    drv_gap         = 0;
    drv_calm        = 0;
    sink_hold       = 0;
    sink_calm       = 0;
    sink_backup     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // still disabled after reset: nothing may change
    push_sample(300, 32'd10);
    push_sample(ReadingMax, 32'hFFFF_FFFF);
    settle();

    write_reg(RegEnabled, CfgDataBits'(1));
    new_setting(8, 50, 6, {10'd1023, 10'd800, 10'd500, 10'd110, 10'd100, 10'd0});
    push_sample(300, 32'd1000);          // arms
    push_sample(302, 32'd1030);          // still settling
    push_sample(900, 32'd1050);          // exactly at the settle time, not judged
    push_sample(308, 32'd1051);          // judged at window edge, no button there
    push_sample(305, 32'd1100);          // idle inside the window
    push_sample(105, 32'd2000);
    push_sample(105, 32'd2100);          // two overlapping buttons match
    push_sample(0, 32'd3000);
    push_sample(0, 32'd3100);
    push_sample(ReadingMax, 32'd4000);
    push_sample(ReadingMax, 32'd4100);
    push_sample(500, 32'd5000);
    push_sample(700, 32'd5100);          // judged but left the window
    push_sample(800, 32'hFFFF_FFF0);
    push_sample(800, 32'h0000_0010);     // wrapped, still settling
    push_sample(801, 32'h0000_0030);     // wrapped, judged
    push_sample(100, 32'd6000);
    push_sample(100, 32'd5999);          // time ran backwards: counts as long elapsed
    push_sample(400, 32'hFFFF_FFFF);
    push_sample(392, 32'h0000_0040);
    settle();

    new_setting($urandom_range(0, 20), $urandom_range(0, 200), 6,
                LevelsBits'({$urandom(), $urandom()}));
    add_press_burst(550);
    settle();

    // tightest window, no settle time, count above the maximum, all levels at full scale
    new_setting(0, 0, 7, {LevelsBits{1'b1}});
    add_press_burst(250);
    settle();

    // widest window, no buttons in use
    new_setting(ReadingMax, $urandom_range(0, 100), 0,
                LevelsBits'({$urandom(), $urandom()}));
    add_press_burst(80);
    settle();

    write_reg(RegEnabled, CfgDataBits'(0));
    settings_used++;
    add_press_burst(100);
    settle();

    write_reg(RegEnabled, CfgDataBits'(1));
    new_setting($urandom_range(1, 40), 65535, $urandom_range(1, 5),
                LevelsBits'({$urandom(), $urandom()}));
    add_press_burst(550);
    settle();

    new_setting($urandom_range(2, 30), $urandom_range(0, 1000), 6,
                LevelsBits'({$urandom(), $urandom()}));
    add_press_burst(250);
    settle();

    if (expected_verdicts.size() != 0) begin
      $error("%0d results never arrived", expected_verdicts.size());
      mismatches++;
    end
    $display("%0d samples over %0d register settings, %0d results checked",
             items_taken, settings_used, results_checked);
    $display("%0d button presses reported, %0d mismatches", presses_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
